@@ hw/rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, payload types and case codes shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W   = 16;                 // coefficient width
    localparam int ROOT_W   = 32;                 // Q16.16 root width
    localparam int OUT_FRAC = 16;                 // root fraction bits
    localparam int D_W      = 2 * COEF_W + 2;     // discriminant, signed
    localparam int RAD_W    = D_W + 2 * OUT_FRAC; // sqrt radicand, D * 2^32
    localparam int SQ_W     = RAD_W / 2;          // sqrt result bits
    localparam int SQ_RW    = SQ_W + 3;           // sqrt partial remainder
    localparam int NUM_W    = SQ_W + 3;           // divider numerator, signed
    localparam int DEN_W    = COEF_W + 1;         // divider denominator, signed
    localparam int QT_W     = NUM_W + 1;          // quotient of 2|n|+|d| / 2|d|
    localparam int DV_W     = DEN_W + 1;          // 2|d|
    localparam int DR_W     = DV_W + 1;           // divider partial remainder
    localparam int DIV_LAT  = QT_W + 1;           // magnitude stage plus one per bit

    localparam logic [QT_W-1:0] Q_POS_MAX =
        {{(QT_W-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
    localparam logic [QT_W-1:0] Q_NEG_MAX = Q_POS_MAX + QT_W'(1);

    localparam logic [2:0] CASE_NONE     = 3'd0;
    localparam logic [2:0] CASE_INFINITE = 3'd1;
    localparam logic [2:0] CASE_LINEAR   = 3'd2;
    localparam logic [2:0] CASE_DOUBLE   = 3'd3;
    localparam logic [2:0] CASE_TWO      = 3'd4;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_in;

    typedef struct packed {
        logic [2:0]               case_code;
        logic signed [ROOT_W-1:0] root_one;
        logic signed [ROOT_W-1:0] root_two;
        logic                     saturated;
    } t_out;

    // travels alongside the square root
    typedef struct packed {
        logic                     vld;
        logic [2:0]               code;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } t_smeta;

    // travels alongside the dividers
    typedef struct packed {
        logic       vld;
        logic [2:0] code;
    } t_dmeta;

endpackage

@@ hw/rtl/qrs_if.sv @@
// ----------------------------------------------------------------------------
// qrs_if
// Valid/ready channels for coefficient beats and result beats.
// ----------------------------------------------------------------------------
interface qrs_in_if;
    logic          valid;
    logic          ready;
    qrs_pkg::t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qrs_out_if;
    logic          valid;
    logic          ready;
    qrs_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/qrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring integer square root of {i_rad, 32'b0}, one result bit
// per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [qrs_pkg::D_W-1:0]   i_rad,
    output logic [qrs_pkg::SQ_W-1:0]  o_root
);
    import qrs_pkg::*;

    logic [SQ_RW-1:0] r_rem  [SQ_W];
    logic [SQ_W-1:0]  r_root [SQ_W];
    logic [RAD_W-1:0] r_rad  [SQ_W];

    for (genvar g = 0; g < SQ_W; g++) begin : g_stg
        logic [SQ_RW-1:0] rem_in;
        logic [SQ_RW-1:0] shifted;
        logic [SQ_RW-1:0] trial;
        logic [SQ_W-1:0]  root_in;
        logic [RAD_W-1:0] rad_in;
        logic [SQ_RW-1:0] n_rem;
        logic [SQ_W-1:0]  n_root;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {i_rad, {(2*OUT_FRAC){1'b0}}};
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
        end

        // remainder stays below 2*root+1, so the top two bits are free
        assign shifted = {rem_in[SQ_RW-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial   = {1'b0, root_in, 2'b01};

        always_comb begin
            if (shifted >= trial) begin
                n_rem  = shifted - trial;
                n_root = {root_in[SQ_W-2:0], 1'b1};
            end else begin
                n_rem  = shifted;
                n_root = {root_in[SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= {rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQ_W-1];

endmodule

@@ hw/rtl/qrs_div.sv @@
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined rounding divider: quotient magnitude (2|n|+|d|) / (2|d|), one
// quotient bit per stage, sign given apart.
// ----------------------------------------------------------------------------
module qrs_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [qrs_pkg::NUM_W-1:0] i_num,
    input  logic signed [qrs_pkg::DEN_W-1:0] i_den,
    output logic [qrs_pkg::QT_W-1:0]         o_quo,
    output logic                             o_neg
);
    import qrs_pkg::*;

    logic [NUM_W-1:0] nm;
    logic [DEN_W-1:0] dm;
    logic [QT_W-1:0]  r_pn;
    logic [DV_W-1:0]  r_pdv;
    logic             r_pneg;

    assign nm = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign dm = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pn   <= {nm, 1'b0} + QT_W'(dm);
            r_pdv  <= {dm, 1'b0};
            r_pneg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end
    end

    logic [DR_W-1:0] r_rem [QT_W];
    logic [QT_W-1:0] r_q   [QT_W];
    logic [QT_W-1:0] r_n   [QT_W];
    logic [DV_W-1:0] r_dv  [QT_W];
    logic            r_neg [QT_W];

    for (genvar g = 0; g < QT_W; g++) begin : g_stg
        logic [DR_W-1:0] rem_in;
        logic [DR_W-1:0] shifted;
        logic [QT_W-1:0] q_in;
        logic [QT_W-1:0] n_in;
        logic [DV_W-1:0] dv_in;
        logic            neg_in;
        logic [DR_W-1:0] n_rem;
        logic [QT_W-1:0] n_q;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign n_in   = r_pn;
            assign dv_in  = r_pdv;
            assign neg_in = r_pneg;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign q_in   = r_q[g-1];
            assign n_in   = r_n[g-1];
            assign dv_in  = r_dv[g-1];
            assign neg_in = r_neg[g-1];
        end

        // remainder is below the divisor, so the top bit is free
        assign shifted = {rem_in[DR_W-2:0], n_in[QT_W-1]};

        always_comb begin
            if (shifted >= {1'b0, dv_in}) begin
                n_rem = shifted - {1'b0, dv_in};
                n_q   = {q_in[QT_W-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {q_in[QT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_q[g]   <= n_q;
                r_n[g]   <= {n_in[QT_W-2:0], 1'b0};
                r_dv[g]  <= dv_in;
                r_neg[g] <= neg_in;
            end
        end
    end

    assign o_quo = r_q[QT_W-1];
    assign o_neg = r_neg[QT_W-1];

endmodule

@@ hw/rtl/quadratic_root_solver_unit.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Real roots of a*x^2 + b*x + c = 0: case code and up to two Q16.16 roots.
// Throughput: one beat per cycle while the output is not stalled, set by the
// fully pipelined square root (one bit per stage) and the two pipelined
// dividers (one bit per stage). A stalled output holds the whole pipeline;
// nothing is dropped. Reset clears every valid bit and the metadata riding
// beside the sqrt and dividers; the other payload registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_in_if.sink     i_in,
    qrs_out_if.source  o_out
);
    import qrs_pkg::*;

    logic en;
    logic r_out_vld;
    t_out r_out;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // stage 0: input register
    logic r_s0_vld;
    t_in  r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= i_in.data;
        end
    end

    // stage 1: products
    logic                       r_s1_vld;
    t_in                        r_s1;
    logic signed [2*COEF_W-1:0] r_s1_bsq;
    logic signed [2*COEF_W-1:0] r_s1_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1     <= r_s0;
            r_s1_bsq <= r_s0.coef_b * r_s0.coef_b;
            r_s1_ac  <= r_s0.coef_a * r_s0.coef_c;
        end
    end

    // stage 2: discriminant and case
    logic signed [D_W-1:0] bsq_x;
    logic signed [D_W-1:0] ac_x;
    logic signed [D_W-1:0] n_d;
    logic [2:0]            n_code;
    logic                  a_z;
    logic                  b_z;
    logic                  c_z;

    assign bsq_x = D_W'(r_s1_bsq);
    assign ac_x  = D_W'(r_s1_ac);
    assign n_d   = bsq_x - (ac_x <<< 2);
    assign a_z   = (r_s1.coef_a == '0);
    assign b_z   = (r_s1.coef_b == '0);
    assign c_z   = (r_s1.coef_c == '0);

    always_comb begin
        if (n_d[D_W-1] || (a_z && b_z && !c_z)) begin
            n_code = CASE_NONE;
        end else if (a_z && b_z) begin
            n_code = CASE_INFINITE;
        end else if (a_z) begin
            n_code = CASE_LINEAR;
        end else if (n_d == '0) begin
            n_code = CASE_DOUBLE;
        end else begin
            n_code = CASE_TWO;
        end
    end

    t_smeta                r_s2;
    logic signed [D_W-1:0] r_s2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (en) begin
            r_s2.vld <= r_s1_vld;
        end
        if (en) begin
            r_s2.code <= n_code;
            r_s2.a    <= r_s1.coef_a;
            r_s2.b    <= r_s1.coef_b;
            r_s2.c    <= r_s1.coef_c;
            r_s2_d    <= n_d;
        end
    end

    // square root, with the coefficients riding alongside
    logic [D_W-1:0]  sq_rad;
    logic [SQ_W-1:0] sq_root;
    t_smeta          r_sq [SQ_W];

    assign sq_rad = r_s2_d[D_W-1] ? '0 : D_W'(r_s2_d);

    qrs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (sq_rad),
        .o_root (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_W; k++) begin
                r_sq[k] <= '0;
            end
        end else if (en) begin
            r_sq[0] <= r_s2;
            for (int k = 1; k < SQ_W; k++) begin
                r_sq[k] <= r_sq[k-1];
            end
        end
    end

    // stage 3: numerators and denominator
    t_smeta                  sm;
    logic signed [NUM_W-1:0] a_n;
    logic signed [NUM_W-1:0] b_n;
    logic signed [NUM_W-1:0] c_n;
    logic signed [NUM_W-1:0] s_n;
    logic signed [NUM_W-1:0] nb;
    logic signed [NUM_W-1:0] n_num1;
    logic signed [NUM_W-1:0] n_num2;
    logic signed [DEN_W-1:0] n_den;

    assign sm     = r_sq[SQ_W-1];
    assign a_n    = NUM_W'(sm.a);
    assign b_n    = NUM_W'(sm.b);
    assign c_n    = NUM_W'(sm.c);
    assign s_n    = {{(NUM_W-SQ_W){1'b0}}, sq_root};
    assign nb     = -(b_n <<< OUT_FRAC);
    assign n_num1 = (sm.a != '0) ? nb + s_n : -(c_n <<< OUT_FRAC);
    assign n_num2 = nb - s_n;
    assign n_den  = (sm.a != '0) ? DEN_W'(a_n <<< 1) : DEN_W'(sm.b);

    t_dmeta                  r_s3;
    logic signed [NUM_W-1:0] r_s3_num1;
    logic signed [NUM_W-1:0] r_s3_num2;
    logic signed [DEN_W-1:0] r_s3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (en) begin
            r_s3.vld <= sm.vld;
        end
        if (en) begin
            r_s3.code <= sm.code;
            r_s3_num1 <= n_num1;
            r_s3_num2 <= n_num2;
            r_s3_den  <= n_den;
        end
    end

    // dividers
    logic [QT_W-1:0] q1;
    logic [QT_W-1:0] q2;
    logic            neg1;
    logic            neg2;
    t_dmeta          r_dm [DIV_LAT];

    qrs_div u_div_one (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s3_num1),
        .i_den (r_s3_den),
        .o_quo (q1),
        .o_neg (neg1)
    );

    qrs_div u_div_two (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s3_num2),
        .i_den (r_s3_den),
        .o_quo (q2),
        .o_neg (neg2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dm[k] <= '0;
            end
        end else if (en) begin
            r_dm[0] <= r_s3;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dm[k] <= r_dm[k-1];
            end
        end
    end

    // output stage: sign, clip, select
    logic signed [ROOT_W-1:0] v1;
    logic signed [ROOT_W-1:0] v2;
    logic                     sat1;
    logic                     sat2;
    logic                     has1;
    logic                     has2;
    t_dmeta                   dm;
    t_out                     n_out;

    assign dm = r_dm[DIV_LAT-1];

    always_comb begin
        if (neg1) begin
            sat1 = (q1 > Q_NEG_MAX);
            v1   = sat1 ? {1'b1, {(ROOT_W-1){1'b0}}} : -$signed(q1[ROOT_W-1:0]);
        end else begin
            sat1 = (q1 > Q_POS_MAX);
            v1   = sat1 ? {1'b0, {(ROOT_W-1){1'b1}}} : $signed(q1[ROOT_W-1:0]);
        end
        if (neg2) begin
            sat2 = (q2 > Q_NEG_MAX);
            v2   = sat2 ? {1'b1, {(ROOT_W-1){1'b0}}} : -$signed(q2[ROOT_W-1:0]);
        end else begin
            sat2 = (q2 > Q_POS_MAX);
            v2   = sat2 ? {1'b0, {(ROOT_W-1){1'b1}}} : $signed(q2[ROOT_W-1:0]);
        end
    end

    always_comb begin
        case (dm.code)
            CASE_LINEAR, CASE_DOUBLE: begin
                has1 = 1'b1;
                has2 = 1'b0;
            end
            CASE_TWO: begin
                has1 = 1'b1;
                has2 = 1'b1;
            end
            default: begin
                has1 = 1'b0;
                has2 = 1'b0;
            end
        endcase
        n_out.case_code = dm.code;
        n_out.root_one  = has1 ? v1 : '0;
        n_out.root_two  = has2 ? v2 : '0;
        n_out.saturated = (has1 && sat1) || (has2 && sat2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dm.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // ------------------------------------------------------------------------
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.data.case_code == CASE_NONE ||
                        o_out.data.case_code == CASE_INFINITE)
        |-> o_out.data.root_one == '0 && o_out.data.root_two == '0 &&
            !o_out.data.saturated)
        else $error("root reported without a root case");

    a_second_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.case_code != CASE_TWO
        |-> o_out.data.root_two == '0)
        else $error("second root outside the two-root case");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.case_code <= CASE_TWO)
        else $error("case code out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result after reset");

endmodule
